// ===== sv/ihpd_pkg.sv =====
// shared types, opcode masks and match functions of the inline hook pattern detector
package ihpd_pkg;

   // instruction set mode codes
   localparam logic [1:0] MODE_ARM   = 2'd0;
   localparam logic [1:0] MODE_THUMB = 2'd1;
   localparam logic [1:0] MODE_A64   = 2'd2;

   // arm opcode masks
   localparam logic [31:0] ARM_LDR_PC_MASK = 32'hfe5ff000;
   localparam logic [31:0] ARM_LDR_PC_VAL  = 32'he41ff000;
   localparam logic [31:0] ARM_B_MASK      = 32'hff000000;
   localparam logic [31:0] ARM_B_VAL       = 32'hea000000;

   // thumb opcode masks
   localparam logic [31:0] T_LDR_PC_MASK = 32'hf000ff7f;
   localparam logic [31:0] T_LDR_PC_VAL  = 32'hf000f85f;
   localparam logic [31:0] T_B_T4_MASK   = 32'hd000f800;
   localparam logic [31:0] T_B_T4_VAL    = 32'h9000f000;
   localparam logic [15:0] T_B_T2_MASK   = 16'hf800;
   localparam logic [15:0] T_B_T2_VAL    = 16'he000;
   localparam logic [15:0] T_NOP_MASK    = 16'hff0f;
   localparam logic [15:0] T_NOP_VAL     = 16'hbf00;
   localparam logic [7:0]  T_MOV_HI      = 8'h46;
   localparam logic [15:0] T_BX_PC       = 16'h4778;

   // aarch64 opcode masks
   localparam logic [31:0] A64_B_MASK    = 32'hfc000000;
   localparam logic [31:0] A64_B_VAL     = 32'h14000000;
   localparam logic [31:0] A64_LDR_MASK  = 32'hff000000;
   localparam logic [31:0] A64_LDR_VAL   = 32'h58000000;
   localparam logic [31:0] A64_ADRP_MASK = 32'h9f000000;
   localparam logic [31:0] A64_ADRP_VAL  = 32'h90000000;
   localparam logic [31:0] A64_BR_MASK   = 32'hfffffc0f;
   localparam logic [31:0] A64_BR_VAL    = 32'hd61f0000;
   localparam logic [31:0] A64_MOV_MASK  = 32'h9f800000;
   localparam logic [31:0] A64_MOV_VAL   = 32'h92800000;

   // number of words after the first that the mov chain may scan
   localparam int A64_CHAIN = 4;

   // per-item flags after the decode stage
   typedef struct packed {
      logic [1:0]            mode;
      logic                  arm_hit;
      logic                  t_direct;
      logic                  t_skip;
      logic                  t_plain;
      logic                  t_skipped;
      logic                  a_b0;
      logic                  a_pair;
      logic                  a_mov0;
      logic [A64_CHAIN-1:0]  a_hit;
      logic [A64_CHAIN-1:0]  a_stop;
   } dec_type;

   // per-item results after the combine stage
   typedef struct packed {
      logic [1:0] mode;
      logic       arm;
      logic       thumb;
      logic       a64;
   } res_type;

   function automatic logic arm_ldr_pc(input logic [31:0] x);
      return (x & ARM_LDR_PC_MASK) == ARM_LDR_PC_VAL;
   endfunction

   function automatic logic arm_b(input logic [31:0] x);
      return (x & ARM_B_MASK) == ARM_B_VAL;
   endfunction

   function automatic logic t_ldr_pc(input logic [31:0] x);
      return (x & T_LDR_PC_MASK) == T_LDR_PC_VAL;
   endfunction

   function automatic logic t_b_t4(input logic [31:0] x);
      return (x & T_B_T4_MASK) == T_B_T4_VAL;
   endfunction

   function automatic logic t_b_t2(input logic [15:0] h);
      return (h & T_B_T2_MASK) == T_B_T2_VAL;
   endfunction

   function automatic logic t_nop(input logic [15:0] h);
      return (h & T_NOP_MASK) == T_NOP_VAL;
   endfunction

   // mov rd, rm with rd equal to rm
   function automatic logic t_mov_same(input logic [15:0] h);
      return (h[15:8] == T_MOV_HI) && (h[6:3] == {h[7], h[2:0]});
   endfunction

   function automatic logic a64_b(input logic [31:0] x);
      return (x & A64_B_MASK) == A64_B_VAL;
   endfunction

   function automatic logic a64_ldr(input logic [31:0] x);
      return (x & A64_LDR_MASK) == A64_LDR_VAL;
   endfunction

   function automatic logic a64_adrp(input logic [31:0] x);
      return (x & A64_ADRP_MASK) == A64_ADRP_VAL;
   endfunction

   function automatic logic a64_br(input logic [31:0] x);
      return (x & A64_BR_MASK) == A64_BR_VAL;
   endfunction

   function automatic logic a64_mov(input logic [31:0] x);
      return (x & A64_MOV_MASK) == A64_MOV_VAL;
   endfunction

endpackage

// ===== sv/ihpd_decode.sv =====
// first stage logic: opcode compares on the raw words
module ihpd_decode (
   input  logic [1:0]       isa_mode,
   input  logic [31:0]      word0,
   input  logic [31:0]      word1,
   input  logic [31:0]      word2,
   input  logic [31:0]      word3,
   input  logic [31:0]      word4,
   output ihpd_pkg::dec_type dec
);

   logic [31:0] t_cur2;
   logic [31:0] t_next2;
   logic [31:0] a_words [ihpd_pkg::A64_CHAIN];
   logic [4:0]  a_reg;

   // thumb view shifted by one halfword
   assign t_cur2  = {word1[15:0], word0[31:16]};
   assign t_next2 = {word2[15:0], word1[31:16]};

   assign a_words[0] = word1;
   assign a_words[1] = word2;
   assign a_words[2] = word3;
   assign a_words[3] = word4;
   assign a_reg      = word0[4:0];

   always_comb begin
      dec.mode    = isa_mode;
      // arm
      dec.arm_hit = ihpd_pkg::arm_ldr_pc(word0) || ihpd_pkg::arm_b(word0);
      // thumb
      dec.t_direct  = ihpd_pkg::t_ldr_pc(word0) || ihpd_pkg::t_b_t4(word0)
                      || ihpd_pkg::t_b_t2(word0[15:0]);
      dec.t_skip    = ihpd_pkg::t_nop(word0[15:0]) || ihpd_pkg::t_mov_same(word0[15:0]);
      dec.t_plain   = ihpd_pkg::t_ldr_pc(word0)
                      || ((word0[15:0] == ihpd_pkg::T_BX_PC) && ihpd_pkg::arm_ldr_pc(word1));
      dec.t_skipped = ihpd_pkg::t_ldr_pc(t_cur2)
                      || ((t_cur2[15:0] == ihpd_pkg::T_BX_PC) && ihpd_pkg::arm_ldr_pc(t_next2));
      // aarch64
      dec.a_b0   = ihpd_pkg::a64_b(word0);
      dec.a_pair = (ihpd_pkg::a64_ldr(word0) || ihpd_pkg::a64_adrp(word0))
                   && ihpd_pkg::a64_br(word1) && (word1[9:5] == a_reg);
      dec.a_mov0 = ihpd_pkg::a64_mov(word0);
      // per chain word: br on the same register, or an end of the search
      for (int i = 0; i < ihpd_pkg::A64_CHAIN; i++) begin
         dec.a_hit[i]  = ihpd_pkg::a64_br(a_words[i]) && (a_words[i][9:5] == a_reg);
         dec.a_stop[i] = (ihpd_pkg::a64_br(a_words[i]) && (a_words[i][9:5] != a_reg))
                         || (ihpd_pkg::a64_mov(a_words[i]) && (a_words[i][4:0] != a_reg));
      end
   end

endmodule

// ===== sv/ihpd_match.sv =====
// second stage logic: per instruction set pattern combine
module ihpd_match (
   input  ihpd_pkg::dec_type dec,
   output ihpd_pkg::res_type res
);

   logic chain;

   // mov chain resolved from the last word back to the first
   always_comb begin
      chain = 1'b0;
      for (int i = ihpd_pkg::A64_CHAIN - 1; i >= 0; i--) begin
         chain = dec.a_hit[i] || (!dec.a_stop[i] && chain);
      end
   end

   always_comb begin
      res.mode  = dec.mode;
      res.arm   = dec.arm_hit;
      res.thumb = dec.t_direct || (dec.t_skip ? dec.t_skipped : dec.t_plain);
      res.a64   = dec.a_b0 || dec.a_pair || (dec.a_mov0 && chain);
   end

endmodule

// ===== sv/inline_hook_pattern_detector.sv =====
// top level of the inline hook pattern detector: three-stage pipeline
//
// Usage:
//  - request channel: req_valid with req_isa_mode and req_word0..req_word4,
//    the first five little-endian words at a function entry; the item is
//    taken at a clock edge with req_valid high and req_stall low
//  - response channel: rsp_valid with rsp_hooked, 1 when the words match a
//    hook trampoline for the given mode; taken when rsp_valid is high and
//    rsp_stall is low; mode code 3 always gives 0
//  - three register stages: opcode compares, pattern combine, mode select
//    into the output register; rsp_valid is the valid bit of that last
//    stage, so a result is held there until it is taken
//  - throughput is one item per cycle while rsp_stall is low; each stage
//    advances on its own, so empty stages keep filling while a result waits at the output
//  - when rsp_stall stays high the pipe fills up and req_stall rises once
//    all three stages hold an item; nothing is dropped or repeated
//  - synchronous reset empties all stages; there is no other state
module inline_hook_pattern_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_isa_mode,
   input  logic [31:0] req_word0,
   input  logic [31:0] req_word1,
   input  logic [31:0] req_word2,
   input  logic [31:0] req_word3,
   input  logic [31:0] req_word4,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hooked
);

   ihpd_pkg::dec_type dec_in;
   ihpd_pkg::dec_type dec_ff;
   ihpd_pkg::res_type res_in;
   ihpd_pkg::res_type res_ff;
   logic              hooked_in;
   logic              hooked_ff;
   logic              v1_ff;
   logic              v2_ff;
   logic              v3_ff;
   logic              rdy1;
   logic              rdy2;
   logic              rdy3;

   // per-stage ready: a stage may load when empty or when it moves on
   assign rdy3 = !v3_ff || !rsp_stall;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall  = !rdy1;
   assign rsp_valid  = v3_ff;
   assign rsp_hooked = hooked_ff;

   // stage one compares
   ihpd_decode u_decode (
      .isa_mode (req_isa_mode),
      .word0    (req_word0),
      .word1    (req_word1),
      .word2    (req_word2),
      .word3    (req_word3),
      .word4    (req_word4),
      .dec      (dec_in)
   );

   // stage two combine
   ihpd_match u_match (
      .dec (dec_ff),
      .res (res_in)
   );

   // stage three mode select
   always_comb begin
      case (res_ff.mode)
         ihpd_pkg::MODE_ARM:   hooked_in = res_ff.arm;
         ihpd_pkg::MODE_THUMB: hooked_in = res_ff.thumb;
         ihpd_pkg::MODE_A64:   hooked_in = res_ff.a64;
         default:              hooked_in = 1'b0;
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rdy1) begin
         dec_ff <= dec_in;
      end
      if (rdy2) begin
         res_ff <= res_in;
      end
      if (rdy3) begin
         hooked_ff <= hooked_in;
      end
   end

endmodule

// ===== verif/hook_checker.sv =====
// checker for the inline hook pattern detector: predicts the hooked flag of every item and compares
module hook_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_isa_mode,
   input  logic [31:0] req_word0,
   input  logic [31:0] req_word1,
   input  logic [31:0] req_word2,
   input  logic [31:0] req_word3,
   input  logic [31:0] req_word4,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_hooked,
   output int          fail_count,
   output int          outstanding
);

   // predicted hooked flags, oldest first
   logic hooked_q[$];

   // arm literal load into pc
   function automatic logic is_arm_ldr_pc(input logic [31:0] x);
      return (x & 32'hfe5ff000) == 32'he41ff000;
   endfunction

   // thumb 32-bit literal load into pc
   function automatic logic is_t32_ldr_pc(input logic [31:0] x);
      return (x & 32'hf000ff7f) == 32'hf000f85f;
   endfunction

   // aarch64 br, bit 4 left free
   function automatic logic is_a64_br(input logic [31:0] x);
      return (x & 32'hfffffc0f) == 32'hd61f0000;
   endfunction

   // aarch64 movz, movn or movk
   function automatic logic is_a64_mov(input logic [31:0] x);
      return (x & 32'h9f800000) == 32'h92800000;
   endfunction

   function automatic logic predict_hooked(input logic [1:0] mode,
                                           input logic [4:0][31:0] w);
      logic [31:0] cur;
      logic [31:0] nxt;
      logic [15:0] h;
      logic [4:0]  reg_id;
      logic        hit;
      logic        done;
      int          i;
      hit = 1'b0;
      case (mode)
         ihpd_pkg::MODE_ARM: begin
            hit = is_arm_ldr_pc(w[0]) || (w[0][31:24] == 8'hea);
         end
         ihpd_pkg::MODE_THUMB: begin
            cur = w[0];
            nxt = w[1];
            h   = w[0][15:0];
            if (is_t32_ldr_pc(cur) || ((cur & 32'hd000f800) == 32'h9000f000) ||
                (h[15:11] == 5'b11100)) begin
               hit = 1'b1;
            end else begin
               // nop or mov to the same register moves the view on by a halfword
               if (((h & 16'hff0f) == 16'hbf00) ||
                   ((h[15:8] == 8'h46) && (h[6:3] == {h[7], h[2:0]}))) begin
                  cur = {w[1][15:0], w[0][31:16]};
                  nxt = {w[2][15:0], w[1][31:16]};
                  h   = cur[15:0];
               end
               hit = is_t32_ldr_pc(cur) || ((h == 16'h4778) && is_arm_ldr_pc(nxt));
            end
         end
         ihpd_pkg::MODE_A64: begin
            hit = (w[0][31:26] == 6'b000101);
            // ldr literal or adrp feeding br on the same register
            if (!hit && ((w[0][31:24] == 8'h58) || (w[0][31] && (w[0][28:24] == 5'b10000))) &&
                is_a64_br(w[1]) && (w[1][9:5] == w[0][4:0]))
               hit = 1'b1;
            // mov chain scanned up to four words for the br
            if (!hit && is_a64_mov(w[0])) begin
               reg_id = w[0][4:0];
               done   = 1'b0;
               for (i = 1; i <= 4; i++) begin
                  if (!done) begin
                     if (is_a64_br(w[i])) begin
                        hit  = (w[i][9:5] == reg_id);
                        done = 1'b1;
                     end else if (is_a64_mov(w[i]) && (w[i][4:0] != reg_id)) begin
                        done = 1'b1;
                     end
                  end
               end
            end
         end
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // compare accepted results first, then queue the prediction of a new item
   always @(posedge clock) begin : compare_hooked
      logic expected;
      if (reset) begin
         fail_count  = 0;
         outstanding = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hooked_q.size() == 0) begin
               $display("%0t: unexpected result, expected none got hooked=%0b",
                        $time, rsp_hooked);
               fail_count++;
            end else begin
               expected = hooked_q.pop_front();
               if (rsp_hooked !== expected) begin
                  $display("%0t: hooked mismatch, expected %0b got %0b",
                           $time, expected, rsp_hooked);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            hooked_q.push_back(predict_hooked(req_isa_mode,
               {req_word4, req_word3, req_word2, req_word1, req_word0}));
         outstanding = hooked_q.size();
      end
   end

endmodule

// ===== verif/testbench.sv =====
// top of the inline hook pattern detector testbench: clock, reset, stimulus and verdict
module testbench;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_PCT     = 29;
   localparam int DRAIN_CYCLES = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_isa_mode;
   logic [31:0] req_word0;
   logic [31:0] req_word1;
   logic [31:0] req_word2;
   logic [31:0] req_word3;
   logic [31:0] req_word4;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_hooked;
   int          fail_count;
   int          outstanding;
   int          cycle_count;
   bit          quiet;

   inline_hook_pattern_detector u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_isa_mode (req_isa_mode),
      .req_word0    (req_word0),
      .req_word1    (req_word1),
      .req_word2    (req_word2),
      .req_word3    (req_word3),
      .req_word4    (req_word4),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hooked   (rsp_hooked)
   );

   hook_checker u_check (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // result side stalls at random except in the quiet stretch
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // random word with the masked bits forced to an opcode
   function automatic logic [31:0] plant(input logic [31:0] mask, input logic [31:0] val);
      return ($urandom & ~mask) | (val & mask);
   endfunction

   // aarch64 br on a given register, bit 4 random
   function automatic logic [31:0] a64_br_word(input logic [4:0] rn);
      return 32'hd61f0000 | {22'd0, rn, 5'd0} | ($urandom & 32'h10);
   endfunction

   // one item, with random idle cycles ahead of it, held until taken
   task automatic send_item(input logic [1:0] mode, input logic [4:0][31:0] w);
      while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_isa_mode <= mode;
      req_word0    <= w[0];
      req_word1    <= w[1];
      req_word2    <= w[2];
      req_word3    <= w[3];
      req_word4    <= w[4];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // well-formed trampolines with random content, noise and broken variants
   task automatic make_pattern(output logic [1:0] mode, output logic [4:0][31:0] w);
      logic [4:0]  reg_id;
      logic [3:0]  rm;
      logic [31:0] cur;
      logic [31:0] nxt;
      logic [15:0] h;
      int          kind;
      int          br_at;
      int          i;
      int          wi;
      int          bi;
      reg_id = 5'($urandom_range(31));
      for (i = 0; i < 5; i++) w[i] = $urandom;
      kind = $urandom_range(12);
      mode = ihpd_pkg::MODE_A64;
      case (kind)
         0: mode = 2'($urandom_range(3));
         1: begin
            mode = ihpd_pkg::MODE_ARM;
            w[0] = plant(32'hfe5ff000, 32'he41ff000);
         end
         2: begin
            mode = ihpd_pkg::MODE_ARM;
            w[0] = plant(32'hff000000, 32'hea000000);
         end
         3: begin
            mode = ihpd_pkg::MODE_THUMB;
            w[0] = plant(32'hf000ff7f, 32'hf000f85f);
         end
         4: begin
            mode = ihpd_pkg::MODE_THUMB;
            w[0] = plant(32'hd000f800, 32'h9000f000);
         end
         5: begin
            mode = ihpd_pkg::MODE_THUMB;
            w[0][15:11] = 5'b11100;
         end
         6, 7: begin
            // halfword skip, then ldr pc or bx pc with arm ldr pc
            mode = ihpd_pkg::MODE_THUMB;
            rm   = 4'($urandom_range(15));
            if ($urandom_range(1))
               h = 16'hbf00 | {8'h00, rm, 4'h0};
            else
               h = {8'h46, rm[3], rm, rm[2:0]};
            if (kind == 6) begin
               cur = plant(32'hf000ff7f, 32'hf000f85f);
               nxt = $urandom;
            end else begin
               cur = {16'($urandom), 16'h4778};
               nxt = plant(32'hfe5ff000, 32'he41ff000);
            end
            w[0] = {cur[15:0], h};
            w[1] = {nxt[15:0], cur[31:16]};
            w[2][15:0] = nxt[31:16];
         end
         8: begin
            mode = ihpd_pkg::MODE_THUMB;
            w[0][15:0] = 16'h4778;
            w[1] = plant(32'hfe5ff000, 32'he41ff000);
         end
         9: w[0] = plant(32'hfc000000, 32'h14000000);
         10: begin
            if ($urandom_range(1))
               w[0] = plant(32'hff000000, 32'h58000000);
            else
               w[0] = plant(32'h9f000000, 32'h90000000);
            w[0][4:0] = reg_id;
            w[1] = a64_br_word(reg_id);
         end
         11: begin
            w[0] = plant(32'h9f800000, 32'h92800000);
            w[0][4:0] = reg_id;
            br_at = $urandom_range(4, 1);
            for (i = 1; i < br_at; i++) begin
               if ($urandom_range(1)) begin
                  w[i] = plant(32'h9f800000, 32'h92800000);
                  w[i][4:0] = reg_id;
               end
            end
            w[br_at] = a64_br_word(reg_id);
         end
         default: begin
            mode = MODE_UNUSED;
            w[0] = $urandom_range(1) ? plant(32'hff000000, 32'hea000000)
                                     : plant(32'hfc000000, 32'h14000000);
         end
      endcase
      // broken sequences: a flipped bit or a wrong mode
      if ($urandom_range(99) < 20) begin
         wi = $urandom_range(4);
         bi = $urandom_range(31);
         w[wi][bi] = ~w[wi][bi];
      end
      if ($urandom_range(99) < 5) mode = 2'($urandom_range(3));
   endtask

   // stimulus and verdict
   initial begin : stimulus
      logic [1:0]       mode;
      logic [4:0][31:0] w;
      int               n;
      reset        = 1'b1;
      quiet        = 1'b0;
      req_valid    = 1'b0;
      req_isa_mode = ihpd_pkg::MODE_ARM;
      req_word0    = '0;
      req_word1    = '0;
      req_word2    = '0;
      req_word3    = '0;
      req_word4    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // arm: ldr pc, branch, extremes, unused words
      send_item(ihpd_pkg::MODE_ARM, {32'h0, 32'h0, 32'h0, 32'h0, 32'he59ff004});
      send_item(ihpd_pkg::MODE_ARM, {32'h0, 32'h0, 32'h0, 32'h0, 32'hea000010});
      send_item(ihpd_pkg::MODE_ARM, {5{32'hffffffff}});
      send_item(ihpd_pkg::MODE_ARM, {5{32'h00000000}});
      send_item(ihpd_pkg::MODE_ARM, {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                     32'hea000000});
      // thumb: direct forms, halfword skips, bx pc, extremes
      send_item(ihpd_pkg::MODE_THUMB, {32'h0, 32'h0, 32'h0, 32'h0, 32'hf000f85f});
      send_item(ihpd_pkg::MODE_THUMB, {32'h0, 32'h0, 32'h0, 32'h0, 32'h9000f000});
      send_item(ihpd_pkg::MODE_THUMB, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0000e7fe});
      send_item(ihpd_pkg::MODE_THUMB, {32'h0, 32'h0, 32'h0, 32'h0000f000, 32'hf85fbf00});
      send_item(ihpd_pkg::MODE_THUMB, {32'h0, 32'h0, 32'h0000e51f, 32'hf0040000,
                                       32'h477846c0});
      send_item(ihpd_pkg::MODE_THUMB, {32'h0, 32'h0, 32'h0, 32'he51ff004, 32'h00004778});
      send_item(ihpd_pkg::MODE_THUMB, {5{32'hffffffff}});
      send_item(ihpd_pkg::MODE_THUMB, {5{32'h00000000}});
      // aarch64: b, ldr and adrp pairs, mov chains, extremes
      send_item(ihpd_pkg::MODE_A64, {32'h0, 32'h0, 32'h0, 32'h0, 32'h17ffffff});
      send_item(ihpd_pkg::MODE_A64, {32'h0, 32'h0, 32'h0, 32'hd61f0220, 32'h58000051});
      send_item(ihpd_pkg::MODE_A64, {32'h0, 32'h0, 32'h0, 32'hd61f0210, 32'h90000010});
      send_item(ihpd_pkg::MODE_A64, {32'h0, 32'h0, 32'h0, 32'hd61f0200, 32'h58000051});
      send_item(ihpd_pkg::MODE_A64, {32'hd61f0200, 32'hd503201f, 32'hf2c00010, 32'hf2a00010,
                                     32'hd2800010});
      send_item(ihpd_pkg::MODE_A64, {32'h0, 32'h0, 32'hd61f0200, 32'hd2800011,
                                     32'hd2800010});
      send_item(ihpd_pkg::MODE_A64, {32'h0, 32'h0, 32'h0, 32'hd61f0220, 32'hd2800010});
      send_item(ihpd_pkg::MODE_A64, {32'hd503201f, 32'hd503201f, 32'hd503201f, 32'hd503201f,
                                     32'hd2800010});
      send_item(ihpd_pkg::MODE_A64, {5{32'hffffffff}});
      send_item(ihpd_pkg::MODE_A64, {5{32'h00000000}});
      // unused mode never matches
      send_item(MODE_UNUSED, {32'h0, 32'h0, 32'h0, 32'h14000000, 32'hea000000});
      send_item(MODE_UNUSED, {5{32'hffffffff}});

      // hold off until the pipe has drained
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);

      // random part with a stretch of no idling and a second drain pause
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 300) && (n < 420);
         if (n == 550) begin
            req_valid <= 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
         make_pattern(mode, w);
         send_item(mode, w);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // wait for the remaining results, then a few more cycles
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ihpd_pkg.sv
sv/ihpd_decode.sv
sv/ihpd_match.sv
sv/inline_hook_pattern_detector.sv
verif/hook_checker.sv
verif/testbench.sv
